>>> sv/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies

package rau_pkg;

    localparam int OpW  = 16;
    localparam int ProdW = 2 * OpW;
    localparam int SumW = 2 * OpW + 1;
    localparam int ResW = 33;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_GT  = 3'd4,
        CMD_RED = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic            start;
        logic [SumW-1:0] dividend;
        logic [SumW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [SumW-1:0] quot;
        logic [SumW-1:0] rem;
    } div_rsp_t;

endpackage

>>> sv/rau_div.sv
// rau_div: shared restoring unsigned divider, one quotient bit per cycle
// depends on rau_pkg

module rau_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0] q_reg, q_next;
    logic [SumW-1:0] r_reg, r_next;
    logic [SumW-1:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SumW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[SumW-1]};
        if (req.start) begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = CntW'(SumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = SumW'(trial - {1'b0, d_reg});
                q_next = {q_reg[SumW-2:0], 1'b1};
            end else begin
                r_next = trial[SumW-1:0];
                q_next = {q_reg[SumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && !req.start) |=> cnt_reg == $past(cnt_reg))
        else $error("divider count moved while idle");
`endif

endmodule

>>> sv/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, sequencer, shared multiplier and divider use
// depends on rau_pkg and rau_div
//
// Usage: one fraction pair and a command enter on the s_ channel (valid/ready);
// one result leaves on the m_ channel (valid/ready). Items are handled one at
// a time: s_ready is high only while the block is idle and no result waits.
// Flow: products are formed in turn on one shared 16x16 multiplier; compare
// finishes there. The gcd uses the shared 33-bit restoring divider (one
// remainder step per Euclid iteration), then two more divisions by the gcd.
// The time an item takes grows with the number of Euclid steps. Error cases
// (zero denominator, unused command) finish without using the divider.
// A result is held on m_ with m_valid until m_ready; no new item is taken
// meanwhile. Reset (aresetn low, synchronous) returns to idle with no
// result pending.

module rational_arithmetic_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_command,
    input  logic signed [15:0]        s_a_num,
    input  logic signed [15:0]        s_a_den,
    input  logic signed [15:0]        s_b_num,
    input  logic signed [15:0]        s_b_den,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [32:0]        m_res_num,
    output logic signed [32:0]        m_res_den,
    output logic                      m_flag,
    output logic                      m_error
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]               cmd_reg;
    logic signed [OpW-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [ProdW-1:0]  p0_reg, p1_reg, p_next;
    logic signed [SumW-1:0]   num_reg, num_next, den_reg, den_next;
    logic [SumW-1:0]          x_reg, x_next, y_reg, y_next;
    logic [SumW-1:0]          g_reg, g_next;
    logic                     flag_reg, flag_next, err_reg, err_next;
    logic                     mv_reg, mv_next;
    logic signed [OpW-1:0]    mul_a, mul_b;
    logic                     s_acc, bad;
    div_req_t                 dreq;
    div_rsp_t                 drsp;

    rau_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign s_acc = s_valid && s_ready;

    // shared multiplier operand select
    always_comb begin
        mul_a = an_reg;
        mul_b = bd_reg;
        unique case (state_reg)
            ST_MUL0: begin mul_a = an_reg; mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg; end
            ST_MUL1: begin mul_a = ad_reg; mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg; end
            ST_MUL2, ST_MUL3: begin mul_a = ad_reg; mul_b = bn_reg; end
            default: begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
        p_next = mul_a * mul_b;
    end

    function automatic logic [SumW-1:0] mag(input logic signed [SumW-1:0] v);
        return v[SumW-1] ? SumW'(-v) : v;
    endfunction

    assign bad = (cmd_reg > CMD_RED) || (ad_reg == '0)
               || (cmd_reg != CMD_RED && bd_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_MUL0;
            ST_MUL0: begin
                if (bad) state_next = ST_DONE;
                else if (cmd_reg == CMD_RED) state_next = ST_PREP;
                else state_next = ST_MUL1;
            end
            ST_MUL1: state_next = (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV) ? ST_MUL3
                                                                             : ST_MUL2;
            ST_MUL2: state_next = (cmd_reg == CMD_GT) ? ST_DONE : ST_MUL3;
            ST_MUL3: state_next = (p1_reg == '0) ? ST_DONE : ST_PREP;
            ST_PREP: state_next = (y_reg == '0) ? ST_DIVN : ST_GCD;
            ST_GCD:  if (drsp.done && drsp.rem == '0) state_next = ST_DIVN;
            ST_DIVN: if (drsp.done) state_next = ST_DIVD;
            ST_DIVD: if (drsp.done) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        num_next = num_reg;
        den_next = den_reg;
        x_next = x_reg;
        y_next = y_reg;
        g_next = g_reg;
        flag_next = flag_reg;
        err_next = err_reg;
        mv_next = mv_reg;
        dreq = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    flag_next = 1'b0;
                    err_next = 1'b0;
                    num_next = '0;
                    den_next = '0;
                end
            end
            ST_MUL0: begin
                if (bad) err_next = 1'b1;
                else if (cmd_reg == CMD_RED) begin
                    num_next = SumW'(an_reg);
                    den_next = SumW'(ad_reg);
                    x_next = mag(SumW'(an_reg));
                    y_next = mag(SumW'(ad_reg));
                end
            end
            ST_MUL2: begin
                if (cmd_reg == CMD_GT) flag_next = (p0_reg > p_next);
            end
            ST_MUL3: begin
                unique case (cmd_reg)
                    CMD_ADD: num_next = SumW'(p0_reg) + SumW'(p_next);
                    CMD_SUB: num_next = SumW'(p0_reg) - SumW'(p_next);
                    default: num_next = SumW'(p0_reg);
                endcase
                den_next = SumW'(p1_reg);
                x_next = mag(num_next);
                y_next = mag(SumW'(p1_reg));
                if (p1_reg == '0) begin
                    err_next = 1'b1;
                    num_next = '0;
                    den_next = '0;
                end
            end
            ST_PREP: begin
                // gcd(x,0) = x; x = 0 gives y directly after one step
                if (y_reg == '0) begin
                    g_next = x_reg;
                    dreq.start = 1'b1;
                    dreq.dividend = mag(num_reg);
                    dreq.divisor = x_reg;
                end else begin
                    dreq.start = 1'b1;
                    dreq.dividend = x_reg;
                    dreq.divisor = y_reg;
                end
            end
            ST_GCD: begin
                if (drsp.done) begin
                    x_next = y_reg;
                    y_next = drsp.rem;
                    dreq.start = 1'b1;
                    if (drsp.rem == '0) begin
                        g_next = y_reg;
                        dreq.dividend = mag(num_reg);
                        dreq.divisor = y_reg;
                    end else begin
                        dreq.dividend = y_reg;
                        dreq.divisor = drsp.rem;
                    end
                end
            end
            ST_DIVN: begin
                if (drsp.done) begin
                    num_next = num_reg[SumW-1] ? SumW'(-drsp.quot) : drsp.quot;
                    dreq.start = 1'b1;
                    dreq.dividend = mag(den_reg);
                    dreq.divisor = g_reg;
                end
            end
            ST_DIVD: begin
                if (drsp.done) begin
                    den_next = den_reg[SumW-1] ? SumW'(-drsp.quot) : drsp.quot;
                    if (cmd_reg == CMD_RED) flag_next = (g_reg == SumW'(1));
                end
            end
            ST_DONE: mv_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
        if (s_acc) begin
            cmd_reg <= s_command;
            an_reg <= s_a_num;
            ad_reg <= s_a_den;
            bn_reg <= s_b_num;
            bd_reg <= s_b_den;
        end
        if (state_reg == ST_MUL0) p0_reg <= p_next;
        if (state_reg == ST_MUL1) p1_reg <= p_next;
        num_reg <= num_next;
        den_reg <= den_next;
        x_reg <= x_next;
        y_reg <= y_next;
        g_reg <= g_next;
        flag_reg <= flag_next;
        err_reg <= err_next;
    end

    assign m_valid   = mv_reg;
    assign m_res_num = num_reg;
    assign m_res_den = den_reg;
    assign m_flag    = flag_reg;
    assign m_error   = err_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> !s_ready) else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && err_reg) |-> (num_reg == '0 && den_reg == '0 && !flag_reg))
        else $error("error result not cleared");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> $stable(num_reg) && $stable(den_reg))
        else $error("result changed while stalled");
`endif

endmodule

>>> tb/rational_arithmetic_unit_test.sv
// rational_arithmetic_unit_test: self-checking testbench for the rational arithmetic unit
// depends on rau_pkg and rational_arithmetic_unit; predicts each reduced fraction
// and checks it against the m_ channel in order
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int unsigned CycleLimit = 10000000;
    localparam int HoldCycles = 4000;
    localparam int PhaseItems = 230;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] an;
        logic signed [15:0] ad;
        logic signed [15:0] bn;
        logic signed [15:0] bd;
    } fraction_req_t;

    typedef struct {
        logic signed [32:0] num;
        logic signed [32:0] den;
        logic               flag;
        logic               err;
    } fraction_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_command = '0;
    logic signed [15:0] s_a_num = '0;
    logic signed [15:0] s_a_den = '0;
    logic signed [15:0] s_b_num = '0;
    logic signed [15:0] s_b_den = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [32:0] m_res_num;
    logic signed [32:0] m_res_den;
    logic m_flag;
    logic m_error;

    fraction_req_t fraction_requests[$];
    fraction_res_t expected_fractions[$];
    int send_idle_pct = 34;
    int recv_idle_pct = 71;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_cnt = 0;
    int mismatches = 0;
    int unsigned cycle_count = 0;

    rational_arithmetic_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_flag    (m_flag),
        .m_error   (m_error)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic fraction_res_t predict_fraction(fraction_req_t r);
        fraction_res_t res;
        longint an, ad, bn, bd, n, d, g;
        an = r.an;
        ad = r.ad;
        bn = r.bn;
        bd = r.bd;
        n = 0;
        d = 0;
        res.flag = 1'b0;
        res.err = 1'b0;
        if (r.cmd > CMD_RED || ad == 0 || (r.cmd != CMD_RED && bd == 0)) begin
            res.err = 1'b1;
        end else if (r.cmd == CMD_GT) begin
            res.flag = (an * bd > bn * ad);
        end else if (r.cmd == CMD_RED) begin
            g = longint'(gcd_of(magnitude(an), magnitude(ad)));
            n = an / g;
            d = ad / g;
            res.flag = (g == 1);
        end else begin
            case (r.cmd)
                CMD_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
                CMD_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
                CMD_MUL: begin n = an * bn; d = ad * bd; end
                default: begin n = an * bd; d = ad * bn; end
            endcase
            if (d == 0) begin
                res.err = 1'b1;
                n = 0;
            end else begin
                g = longint'(gcd_of(magnitude(n), magnitude(d)));
                n = n / g;
                d = d / g;
            end
        end
        res.num = n[32:0];
        res.den = d[32:0];
        return res;
    endfunction

    task automatic queue_fraction(logic [2:0] cmd, logic signed [15:0] an,
                                  logic signed [15:0] ad, logic signed [15:0] bn,
                                  logic signed [15:0] bd);
        fraction_req_t r;
        r.cmd = cmd;
        r.an = an;
        r.ad = ad;
        r.bn = bn;
        r.bd = bd;
        fraction_requests.push_back(r);
    endtask

    // mix of extremes, small values that share factors, and full-range values
    function automatic logic signed [15:0] pick_operand(bit allow_zero);
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = 16'sd1;
                    3: v = -16'sd1;
                    default: v = 16'sd0;
                endcase
            end
            1, 2, 3: begin
                v = 16'($urandom_range(0, 60));
                if ($urandom_range(0, 1)) v = -v;
            end
            4: v = 16'($urandom_range(1, 16) * 12);
            default: v = 16'($urandom);
        endcase
        if (v == 0 && !allow_zero) v = 16'sd1;
        if (allow_zero && $urandom_range(0, 39) == 0) v = 16'sd0;
        return v;
    endfunction

    task automatic queue_random(int count);
        logic [2:0] cmd;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 29) == 0) cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
            else cmd = 3'($urandom_range(0, 5));
            queue_fraction(cmd, pick_operand(1'b1), pick_operand($urandom_range(0, 9) == 0),
                           pick_operand(1'b1), pick_operand($urandom_range(0, 9) == 0));
        end
    endtask

    task automatic wait_drained();
        while (fraction_requests.size() != 0 || s_valid || expected_fractions.size() != 0)
            @(posedge aclk);
    endtask

    // driver: predict on acceptance, then present the next transaction
    always @(posedge aclk) begin
        fraction_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                r.cmd = s_command;
                r.an = s_a_num;
                r.ad = s_a_den;
                r.bn = s_b_num;
                r.bd = s_b_den;
                expected_fractions.push_back(predict_fraction(r));
            end
            if (!s_valid || s_ready) begin
                if (fraction_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = fraction_requests.pop_front();
                    s_command <= r.cmd;
                    s_a_num <= r.an;
                    s_a_den <= r.ad;
                    s_b_num <= r.bn;
                    s_b_den <= r.bd;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt <= HoldCycles;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        fraction_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fractions.size() == 0) begin
                $display("%0t: unexpected result transaction num=%0d den=%0d flag=%0b err=%0b",
                         $time, m_res_num, m_res_den, m_flag, m_error);
                mismatches++;
            end else begin
                e = expected_fractions.pop_front();
                if (m_res_num !== e.num) begin
                    $display("%0t: res_num expected %0d actual %0d", $time, e.num, m_res_num);
                    mismatches++;
                end
                if (m_res_den !== e.den) begin
                    $display("%0t: res_den expected %0d actual %0d", $time, e.den, m_res_den);
                    mismatches++;
                end
                if (m_flag !== e.flag) begin
                    $display("%0t: flag expected %0b actual %0b", $time, e.flag, m_flag);
                    mismatches++;
                end
                if (m_error !== e.err) begin
                    $display("%0t: error expected %0b actual %0b", $time, e.err, m_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every command, extremes, zero denominators, zero numerators
        queue_fraction(CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        queue_fraction(CMD_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
        queue_fraction(CMD_MUL, 16'sd6, -16'sd4, -16'sd10, 16'sd9);
        queue_fraction(CMD_DIV, 16'sd3, 16'sd4, -16'sd9, 16'sd8);
        queue_fraction(CMD_GT, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        queue_fraction(CMD_GT, 16'sd1, 16'sd3, 16'sd1, 16'sd3);
        queue_fraction(CMD_RED, 16'sd12, -16'sd18, 16'sd0, 16'sd0);
        queue_fraction(CMD_RED, 16'sd7, 16'sd9, 16'sd5, 16'sd3);
        queue_fraction(CMD_RED, 16'sd0, -16'sd5, 16'sd1, 16'sd1);
        queue_fraction(CMD_ADD, 16'sd0, 16'sd7, 16'sd0, -16'sd3);
        queue_fraction(CMD_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2);
        queue_fraction(CMD_MUL, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
        queue_fraction(CMD_RED, 16'sd4, 16'sd0, 16'sd1, 16'sd1);
        queue_fraction(CMD_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5);
        queue_fraction(CMD_SPARE6, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        queue_fraction(CMD_SPARE7, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        queue_fraction(CMD_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        queue_fraction(CMD_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        queue_fraction(CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_fraction(CMD_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        queue_fraction(CMD_GT, 16'sh8000, 16'sd1, 16'sh7fff, 16'sh8000);
        queue_fraction(CMD_RED, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
        queue_fraction(CMD_RED, 16'sh8000, -16'sd1, 16'sd0, 16'sd0);
        queue_fraction(CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        queue_random(PhaseItems);
        wait_drained();

        // swap idling; long receiver stall while the sender keeps offering
        send_idle_pct = 71;
        recv_idle_pct = 34;
        hold_req <= 1'b1;
        queue_random(PhaseItems);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(PhaseItems);
        wait_drained();

        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/rau_pkg.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
